// ===== hw/rtl/periodic_timer_slots_assert.svh =====
// Assertion macros for the RTL of the timer slot block (used by periodic_timer_slots.sv).
`ifndef PERIODIC_TIMER_SLOTS_ASSERT_SVH
`define PERIODIC_TIMER_SLOTS_ASSERT_SVH

`ifndef SYNTHESIS

`define PTS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("periodic_timer_slots: assertion failed");

`define PTS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("periodic_timer_slots: assertion failed");

`else

`define PTS_ASSERT(lbl, clk, rst_n, prop)

`define PTS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hw/rtl/pts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

  localparam int SLOTS     = 8;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RES_CAP   = 8;
  localparam int N_W       = $clog2(RES_CAP + 1);
  localparam int CNT_W     = 32;
  localparam int TAG_W     = 8;
  localparam int OIDX_W    = 3;
  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_REG   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_CHECK = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] start;
    logic [CNT_W-1:0] period;
  } slot_t;

  function automatic logic [OIDX_W-1:0] idx_to_out(input logic [IDX_W-1:0] idx);
    logic [IDX_W+OIDX_W-1:0] wide;
    wide = {{OIDX_W{1'b0}}, idx};
    return wide[OIDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pts_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pts_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire pts_pkg::slot_t slot_in,
  output pts_pkg::slot_t     slot_out
);

  logic [pts_pkg::TAG_W-1:0] tag_r;
  logic [pts_pkg::CNT_W-1:0] start_r;
  logic [pts_pkg::CNT_W-1:0] period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (shift_en) begin
      tag_r <= slot_in.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      start_r  <= slot_in.start;
      period_r <= slot_in.period;
    end
  end

  assign slot_out = {tag_r, start_r, period_r};

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_timer_slots.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake          | Payload
// in_     | slave     | in_tvalid/tready   | tdata: tag, duration, stamp; tuser: func
// out_    | master    | out_tvalid/tready  | tdata: tag, index, full, elapsed, count
//
// A tick or a register beat rotates the slot ring once through all SLOTS cells,
// then loads the final beat; the next beat is accepted only after that load.
// A read or a check beat skips the ring and goes straight to the final beat.
// Synchronous active-low reset frees all slots and clears the counter.
// A second fired slot that meets a full output register halts the ring rotation.

`include "periodic_timer_slots_assert.svh"

module periodic_timer_slots (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [7:0] tag, [39:8] duration, [71:40] stamp
  input  wire logic [pts_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] func
  input  wire logic [1:0]                       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] fired_tag, [10:8] slot_index, [11] full_res, [12] elapsed,
  // [44:13] count_now, [47:45] zero
  output logic [pts_pkg::OUT_DATA_W-1:0]        out_tdata,
  // [0] fired_valid
  output logic                                  out_tuser,
  output logic                                  out_tlast
);

  pts_pkg::state_t state_r, state_nxt;
  pts_pkg::func_t  op_r;

  logic [pts_pkg::TAG_W-1:0]  tag_r;
  logic [pts_pkg::CNT_W-1:0]  dur_r;
  logic                       elapsed_r;
  logic [pts_pkg::CNT_W-1:0]  cnt_r;
  logic [pts_pkg::IDX_W-1:0]  idx_r;
  logic [pts_pkg::N_W-1:0]    n_r;
  logic                       found_r;
  logic [pts_pkg::OIDX_W-1:0] found_idx_r;
  logic                       pend_valid_r;
  logic [pts_pkg::TAG_W-1:0]  pend_tag_r;
  logic [pts_pkg::OIDX_W-1:0] pend_idx_r;

  logic                       out_valid_r;
  logic                       out_fv_r;
  logic [pts_pkg::TAG_W-1:0]  out_tag_r;
  logic [pts_pkg::OIDX_W-1:0] out_idx_r;
  logic                       out_full_r;
  logic                       out_el_r;
  logic [pts_pkg::CNT_W-1:0]  out_cnt_r;
  logic                       out_last_r;

  logic [pts_pkg::TAG_W-1:0]  in_tag;
  logic [pts_pkg::CNT_W-1:0]  in_dur;
  logic [pts_pkg::CNT_W-1:0]  in_stamp;
  logic                       in_fire;
  logic                       out_free;
  logic                       is_tick;
  logic                       fire_hit;
  logic                       report;
  logic                       take;
  logic                       step;
  logic                       scan_end;
  logic                       push_pend;
  logic                       done_load;
  pts_pkg::slot_t             head;
  pts_pkg::slot_t             fb;
  pts_pkg::slot_t             chain [pts_pkg::SLOTS];

  assign in_tag   = in_tdata[7:0];
  assign in_dur   = in_tdata[39:8];
  assign in_stamp = in_tdata[71:40];

  // Slot ring: cell 0 is evaluated, each cell takes its upper neighbor, the top cell takes the feedback.
  for (genvar i = 0; i < pts_pkg::SLOTS; i++) begin : g_cell
    pts_pkg::slot_t cell_in;
    if (i == pts_pkg::SLOTS - 1) begin : g_tail
      assign cell_in = fb;
    end else begin : g_mid
      assign cell_in = chain[i+1];
    end
    pts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (step),
      .slot_in  (cell_in),
      .slot_out (chain[i])
    );
  end

  assign head     = chain[0];
  assign out_free = !out_valid_r || out_tready;
  assign is_tick  = (op_r == pts_pkg::FUNC_TICK);
  assign fire_hit = (head.tag != '0) && ((cnt_r - head.start) > head.period);
  assign report   = is_tick && fire_hit && (n_r < pts_pkg::N_W'(pts_pkg::RES_CAP));
  assign take     = (op_r == pts_pkg::FUNC_REG) && (head.tag == '0) && !found_r;
  assign scan_end = (idx_r == pts_pkg::IDX_W'(pts_pkg::SLOTS - 1));
  assign in_fire  = in_tvalid && in_tready;

  always_comb begin
    fb = head;
    if (is_tick && fire_hit) begin
      fb.start = cnt_r;
    end
    if (take) begin
      fb.tag    = tag_r;
      fb.start  = cnt_r;
      fb.period = dur_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pts_pkg::ST_IDLE: begin
        if (in_fire) begin
          if ((in_tuser == pts_pkg::FUNC_TICK) || (in_tuser == pts_pkg::FUNC_REG)) begin
            state_nxt = pts_pkg::ST_SCAN;
          end else begin
            state_nxt = pts_pkg::ST_DONE;
          end
        end
      end
      pts_pkg::ST_SCAN: begin
        if (step && scan_end) begin
          state_nxt = pts_pkg::ST_DONE;
        end
      end
      pts_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = pts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    step      = 1'b0;
    done_load = 1'b0;
    case (state_r)
      pts_pkg::ST_IDLE: in_tready = 1'b1;
      pts_pkg::ST_SCAN: step = !(report && pend_valid_r && !out_free);
      pts_pkg::ST_DONE: done_load = out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign push_pend = step && report && pend_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pts_pkg::ST_IDLE;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && (in_tuser == pts_pkg::FUNC_TICK)) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (in_fire) begin
        pend_valid_r <= 1'b0;
      end else if (step && report) begin
        pend_valid_r <= 1'b1;
      end
      if (done_load || push_pend) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r      <= pts_pkg::func_t'(in_tuser);
      tag_r     <= in_tag;
      dur_r     <= in_dur;
      elapsed_r <= (cnt_r - in_stamp) > in_dur;
      idx_r     <= '0;
      n_r       <= '0;
      found_r   <= 1'b0;
    end else if (step) begin
      idx_r <= idx_r + 1'b1;
      if (report) begin
        n_r        <= n_r + 1'b1;
        pend_tag_r <= head.tag;
        pend_idx_r <= pts_pkg::idx_to_out(idx_r);
      end
      if (take) begin
        found_r     <= 1'b1;
        found_idx_r <= pts_pkg::idx_to_out(idx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_pend) begin
      out_fv_r   <= 1'b1;
      out_tag_r  <= pend_tag_r;
      out_idx_r  <= pend_idx_r;
      out_full_r <= 1'b0;
      out_el_r   <= 1'b0;
      out_cnt_r  <= cnt_r;
      out_last_r <= 1'b0;
    end else if (done_load) begin
      out_fv_r   <= 1'b0;
      out_tag_r  <= '0;
      out_idx_r  <= '0;
      out_full_r <= 1'b0;
      out_el_r   <= 1'b0;
      out_cnt_r  <= cnt_r;
      out_last_r <= 1'b1;
      case (op_r)
        pts_pkg::FUNC_TICK: begin
          if (pend_valid_r) begin
            out_fv_r  <= 1'b1;
            out_tag_r <= pend_tag_r;
            out_idx_r <= pend_idx_r;
          end
        end
        pts_pkg::FUNC_REG: begin
          out_full_r <= !found_r;
          if (found_r) begin
            out_idx_r <= found_idx_r;
          end
        end
        pts_pkg::FUNC_CHECK: out_el_r <= elapsed_r;
        default: out_el_r <= 1'b0;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_el_r, out_full_r, out_idx_r, out_tag_r};
  assign out_tuser  = out_fv_r;
  assign out_tlast  = out_last_r;

  `PTS_ASSERT(a_cnt_held_busy, clk, rst_n, (state_r != pts_pkg::ST_IDLE) |=> $stable(cnt_r))
  `PTS_ASSERT(a_pend_only_tick, clk, rst_n, pend_valid_r |-> (op_r == pts_pkg::FUNC_TICK))
  `PTS_ASSERT(a_scan_ends, clk, rst_n, (step && scan_end) |=> (state_r == pts_pkg::ST_DONE))
  `PTS_ASSERT(a_fired_tag_set, clk, rst_n, (out_valid_r && out_fv_r) |-> (out_tag_r != '0))

endmodule

`default_nettype wire
